>>> rtl/psb_pkg.sv
// ----------------------------------------------------------------------------
// psb_pkg
// Shared types, codes and constants of the per-session packet stack bank.
// ----------------------------------------------------------------------------
package psb_pkg;

	// Fixed field widths of the request and response words
	localparam int SESS_W  = 4;
	localparam int WORD_W  = 64;
	localparam int CNT_W   = 7;
	localparam int STAT_W  = 2;

	// Sessions that the session field can name at all
	localparam int SESS_LIMIT = 16;

	// Most packets that one pull may return
	localparam int MAX_RESULTS = 64;

	// Parameter defaults
	localparam int SESSION_BOUND_DEF = 16;
	localparam int STACK_DEPTH_DEF   = 64;
	localparam int PACKET_BITS_DEF   = 64;

	// Operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_PULL = 1'b1;

	// Response status codes
	localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD_SESSION = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL        = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY       = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_PULL
	} state_t;

	typedef struct packed {
		logic              operation;
		logic [SESS_W-1:0] session;
		logic [WORD_W-1:0] packet_word;
		logic [CNT_W-1:0]  pull_count;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [WORD_W-1:0] packet_out;
		logic              has_packet;
		logic              last_result;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic              cap;
		logic              emit;
		logic [STAT_W-1:0] emit_status;
		logic              push;
		logic              start_pull;
		logic              issue;
		logic              move;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic bad;
		logic is_push;
		logic full;
		logic none;
		logic rem_nz;
		logic pend;
		logic pend_last;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/per_session_packet_stack_bank_top.sv
// ----------------------------------------------------------------------------
// per_session_packet_stack_bank_top
// One LIFO packet stack per session in a shared memory, push and pull access.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_valid / req_stall / req) carries one word: a push
//    of packet_word onto a session's stack, or a pull of up to pull_count
//    packets from its top. Response channel (rsp_valid / rsp_stall / rsp)
//    returns one word per removed packet, most recent first, or a single
//    status word. The final word of each request has last_result set.
//  - A request is taken only while the sequencer is idle. A push, a status
//    answer or a bad session is decided from the held request and loads the
//    response register once it is free, and the sequencer is then idle
//    again. A pull fetches its packets through the memory read register into
//    the response register, one per cycle while the receiver does not stall,
//    and the sequencer is idle again once the last packet has moved out. The
//    stack memory's single registered read port sets this pull rate.
//  - Reset clears all fill counts, so every stack starts empty; the stack
//    memory itself needs no clearing.
//  - When the receiver stalls, the response register holds its word and the
//    pull stops fetching; one fetched packet waits in the memory read
//    register, and nothing is dropped.
// ----------------------------------------------------------------------------
module per_session_packet_stack_bank_top #(
	parameter int SESSION_BOUND = psb_pkg::SESSION_BOUND_DEF,
	parameter int STACK_DEPTH   = psb_pkg::STACK_DEPTH_DEF,
	parameter int PACKET_BITS   = psb_pkg::PACKET_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  psb_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output psb_pkg::rsp_t rsp
);

	psb_pkg::cmd_t cmd;
	psb_pkg::sts_t sts;

	// Sequencer: decide the request, then step the pull
	psb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Storage, fill counts and the response register
	psb_dp #(
		.SESSION_BOUND(SESSION_BOUND),
		.STACK_DEPTH  (STACK_DEPTH),
		.PACKET_BITS  (PACKET_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// A packet word always reports ok
	a_packet_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.has_packet |-> (rsp.status == psb_pkg::ST_OK))
		else $error("packet word with non-ok status");

	// A waiting response keeps its word
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// No new request is taken while a pull is still streaming
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.has_packet && !rsp.last_result |-> req_stall)
		else $error("request accepted in the middle of a pull");

endmodule

>>> rtl/psb_ram.sv
// ----------------------------------------------------------------------------
// psb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module psb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Hold read data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/psb_ctrl.sv
// ----------------------------------------------------------------------------
// psb_ctrl
// Sequencer: takes one request word, decides it, and steps a pull.
// ----------------------------------------------------------------------------
module psb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  psb_pkg::sts_t sts,
	output psb_pkg::cmd_t cmd
);

	psb_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psb_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		req_stall = (state_q != psb_pkg::S_IDLE);
		unique case (state_q)
			psb_pkg::S_IDLE: begin
				if (req_valid) begin
					cmd.cap   = 1'b1;
					state_nxt = psb_pkg::S_EXEC;
				end
			end
			psb_pkg::S_EXEC: begin
				if (sts.bad) begin
					if (sts.out_free) begin
						cmd.emit        = 1'b1;
						cmd.emit_status = psb_pkg::ST_BAD_SESSION;
						state_nxt       = psb_pkg::S_IDLE;
					end
				end else if (sts.is_push) begin
					if (sts.out_free) begin
						cmd.emit  = 1'b1;
						state_nxt = psb_pkg::S_IDLE;
						if (sts.full) begin
							cmd.emit_status = psb_pkg::ST_FULL;
						end else begin
							cmd.push        = 1'b1;
							cmd.emit_status = psb_pkg::ST_OK;
						end
					end
				end else if (sts.none) begin
					if (sts.out_free) begin
						cmd.emit        = 1'b1;
						cmd.emit_status = psb_pkg::ST_EMPTY;
						state_nxt       = psb_pkg::S_IDLE;
					end
				end else begin
					cmd.start_pull = 1'b1;
					state_nxt      = psb_pkg::S_PULL;
				end
			end
			psb_pkg::S_PULL: begin
				// Move a fetched packet out, refetch behind it
				cmd.move  = sts.pend && sts.out_free;
				cmd.issue = sts.rem_nz && (!sts.pend || cmd.move);
				if (cmd.move && sts.pend_last) begin
					state_nxt = psb_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = psb_pkg::S_IDLE;
			end
		endcase
	end

	a_pull_exits_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == psb_pkg::S_PULL) && cmd.move && sts.pend_last
		|=> (state_q == psb_pkg::S_IDLE))
		else $error("pull did not end after its last packet");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap |-> (state_q == psb_pkg::S_IDLE))
		else $error("request captured while busy");

	a_emit_one_source: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit && (cmd.move || cmd.issue)))
		else $error("status and packet emitted together");

endmodule

>>> rtl/psb_dp.sv
// ----------------------------------------------------------------------------
// psb_dp
// Datapath: request registers, fill counters, stack memory, response register.
// ----------------------------------------------------------------------------
module psb_dp #(
	parameter int SESSION_BOUND = psb_pkg::SESSION_BOUND_DEF,
	parameter int STACK_DEPTH   = psb_pkg::STACK_DEPTH_DEF,
	parameter int PACKET_BITS   = psb_pkg::PACKET_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  psb_pkg::req_t req,
	input  psb_pkg::cmd_t cmd,
	output psb_pkg::sts_t sts,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output psb_pkg::rsp_t rsp
);

	localparam int NSESS  = (SESSION_BOUND < psb_pkg::SESS_LIMIT) ?
	                        SESSION_BOUND : psb_pkg::SESS_LIMIT;
	localparam int SIDX_W = (NSESS > 1) ? $clog2(NSESS) : 1;
	localparam int FW     = $clog2(STACK_DEPTH + 1);
	localparam int LW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int MDEPTH = NSESS * STACK_DEPTH;
	localparam int AW     = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
	localparam int CNT_W  = psb_pkg::CNT_W;
	localparam int CW     = (FW > CNT_W) ? FW : CNT_W;

	logic                        op_q;
	logic [psb_pkg::SESS_W-1:0]  sess_q;
	logic [PACKET_BITS-1:0]      word_q;
	logic [CNT_W-1:0]            want_q;

	logic [FW-1:0]    fill_q [NSESS];
	logic [CNT_W-1:0] rem_q;
	logic [LW-1:0]    ptr_q;
	logic             pend_q;
	logic             pend_last_q;
	logic             out_valid_q;
	psb_pkg::rsp_t    out_q;

	logic [SIDX_W-1:0]      idx;
	logic [FW-1:0]          fill_cur;
	logic [CNT_W-1:0]       want_sat;
	logic [CNT_W-1:0]       n;
	logic                   sess_ok;
	logic [AW-1:0]          waddr;
	logic [AW-1:0]          raddr;
	logic [PACKET_BITS-1:0] rdata;
	logic                   out_free;

	// Hold the request word
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q   <= req.operation;
			sess_q <= req.session;
			word_q <= req.packet_word[PACKET_BITS-1:0];
			want_q <= req.pull_count;
		end
	end

	always_comb begin
		idx      = sess_q[SIDX_W-1:0];
		sess_ok  = (sess_q != '0) && (32'(sess_q) < 32'(SESSION_BOUND));
		fill_cur = fill_q[idx];
		want_sat = (want_q > CNT_W'(psb_pkg::MAX_RESULTS)) ?
		           CNT_W'(psb_pkg::MAX_RESULTS) : want_q;
		if (CW'(want_sat) < CW'(fill_cur)) begin
			n = want_sat;
		end else begin
			n = CNT_W'(fill_cur);
		end
		waddr = AW'(32'(idx) * 32'(STACK_DEPTH) + 32'(fill_cur[LW-1:0]));
		raddr = AW'(32'(idx) * 32'(STACK_DEPTH) + 32'(ptr_q));
	end

	assign out_free = !out_valid_q || !rsp_stall;

	always_comb begin
		sts.bad       = !sess_ok;
		sts.is_push   = (op_q == psb_pkg::OP_PUSH);
		sts.full      = (fill_cur == FW'(STACK_DEPTH));
		sts.none      = (n == '0);
		sts.rem_nz    = (rem_q != '0);
		sts.pend      = pend_q;
		sts.pend_last = pend_last_q;
		sts.out_free  = out_free;
	end

	// Advance fill counts on push and at the start of a pull
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSESS; i++) begin
				fill_q[i] <= '0;
			end
		end else if (cmd.push) begin
			fill_q[idx] <= fill_cur + FW'(1);
		end else if (cmd.start_pull) begin
			fill_q[idx] <= fill_cur - FW'(n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			pend_q      <= 1'b0;
			pend_last_q <= 1'b0;
		end else begin
			if (cmd.start_pull) begin
				rem_q <= n;
			end else if (cmd.issue) begin
				rem_q <= rem_q - CNT_W'(1);
			end
			if (cmd.issue) begin
				pend_q      <= 1'b1;
				pend_last_q <= (rem_q == CNT_W'(1));
			end else if (cmd.move) begin
				pend_q      <= 1'b0;
				pend_last_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_pull) begin
			ptr_q <= LW'(fill_cur - FW'(1));
		end else if (cmd.issue) begin
			ptr_q <= ptr_q - LW'(1);
		end
	end

	psb_ram #(
		.WIDTH(PACKET_BITS),
		.DEPTH(MDEPTH)
	) u_stack_ram (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(waddr),
		.wdata(word_q),
		.re   (cmd.issue),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.move) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.status      <= cmd.emit_status;
			out_q.packet_out  <= '0;
			out_q.has_packet  <= 1'b0;
			out_q.last_result <= 1'b1;
		end else if (cmd.move) begin
			out_q.status      <= psb_pkg::ST_OK;
			out_q.packet_out  <= psb_pkg::WORD_W'(rdata);
			out_q.has_packet  <= 1'b1;
			out_q.last_result <= pend_last_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.has_packet |-> out_q.last_result && (out_q.packet_out == '0))
		else $error("status-only response not marked last");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		pend_last_q |-> (rem_q == '0))
		else $error("last packet fetched with reads still owed");

	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_pull |-> (n != '0) && !pend_q && (rem_q == '0))
		else $error("pull started with fetch still in flight");

endmodule
